// ===== src/bba_pkg.sv =====
`timescale 1ns / 1ps

package bba_pkg;

  // default geometry
  localparam int DEF_POOL_BYTES      = 65536;
  localparam int DEF_MIN_BLOCK_BYTES = 32;
  localparam int DEF_NODE_COUNT      = 4095;

  // fixed field widths
  localparam int REQ_W = 20;
  localparam int OFF_W = 16;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // node marks
  typedef logic [1:0] mark_t;
  localparam mark_t MARK_FREE  = 2'd0;
  localparam mark_t MARK_USED  = 2'd1;
  localparam mark_t MARK_SPLIT = 2'd2;

endpackage

// ===== src/buddy_block_allocator_core.sv =====
`timescale 1ns / 1ps

// channel | ports                                              | word accepted when
// --------+----------------------------------------------------+----------------------
// in      | in_valid in_ready in_kind in_request_bytes         | in_valid & in_ready
//         | in_block_offset                                    |
// out     | out_valid out_ready out_granted out_granted_offset | out_valid & out_ready
//
// after reset a clearing pass writes every node mark free (NODE_COUNT marks,
//   4095 by default) with in_ready low
// allocate: double the minimum block until it covers the request, then for each node
//   read a mark memory read and then a decide step; a node turned away unread and each
//   backtrack step go through the unwind state; the result is then delivered
// free: a read and a decide per level down, a check and a sibling read per merge, then deliver
// one word is in the walk at a time; a finished walk holds in_ready low until the
//   result register frees, so a new word enters while the last result waits on out_ready

module buddy_block_allocator_core
  import bba_pkg::*;
#(
  parameter int POOL_BYTES      = DEF_POOL_BYTES,
  parameter int MIN_BLOCK_BYTES = DEF_MIN_BLOCK_BYTES,
  parameter int NODE_COUNT      = DEF_NODE_COUNT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_kind,
  input  logic [REQ_W-1:0] in_request_bytes,
  input  logic [OFF_W-1:0] in_block_offset,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_granted,
  output logic [OFF_W-1:0] out_granted_offset
);

  localparam int POOL_W = $clog2(POOL_BYTES);
  // sizes and rounded requests; rounding may pass the pool by one doubling
  localparam int VAL_W  = (POOL_W + 2 > 14) ? POOL_W + 2 : 14;
  localparam int CW     = (VAL_W > REQ_W) ? VAL_W : REQ_W;
  localparam int TW     = (POOL_W + 1 > OFF_W) ? POOL_W + 1 : OFF_W;
  localparam int BASE_W = POOL_W;
  localparam int NODE_W = $clog2(NODE_COUNT);
  // node index also holds absent child indices up to 2*NODE_COUNT
  localparam int NIDX_W = $clog2(NODE_COUNT + 1) + 1;
  localparam int LVL    = $clog2(NODE_COUNT + 1);
  localparam int DEP_W  = $clog2(LVL + 1);

  typedef enum logic [10:0] {
    ST_CLEAR    = 11'b00000000001,
    ST_IDLE     = 11'b00000000010,
    ST_ROUND    = 11'b00000000100,
    ST_A_VISIT  = 11'b00000001000,
    ST_A_DECIDE = 11'b00000010000,
    ST_A_UNWIND = 11'b00000100000,
    ST_F_VISIT  = 11'b00001000000,
    ST_F_DECIDE = 11'b00010000000,
    ST_F_CHECK  = 11'b00100000000,
    ST_F_SIB    = 11'b01000000000,
    ST_RESP     = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [NODE_W-1:0] clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;

  // walk registers
  logic [VAL_W-1:0]  want_r, want_nxt;
  logic [REQ_W-1:0]  bytes_r, bytes_nxt;
  logic [OFF_W-1:0]  target_r, target_nxt;
  logic [NIDX_W-1:0] n_r, n_nxt;
  logic [DEP_W-1:0]  d_r, d_nxt;
  logic [VAL_W-1:0]  size_r, size_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  logic [LVL:0]      fresh_r, fresh_nxt;   // node at this depth was split by this walk
  logic              cm_free_r, cm_free_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic [OFF_W-1:0]  res_off_r, res_off_nxt;
  logic              out_granted_r, out_granted_nxt;
  logic [OFF_W-1:0]  out_offset_r, out_offset_nxt;

  // mark memory port
  logic              mem_wr_en;
  logic [NODE_W-1:0] mem_wr_addr;
  mark_t             mem_wr_data;
  logic              mem_rd_en;
  logic [NODE_W-1:0] mem_rd_addr;
  mark_t             mem_rd_data;

  // tree arithmetic
  logic                     n_odd;
  logic                     absent;
  logic [NIDX_W-1:0]        parent_idx;
  logic [NIDX_W-1:0]        sibling_idx;
  logic [NIDX_W-1:0]        right_of_parent;
  logic [NIDX_W-1:0]        left_child;
  logic [NIDX_W-1:0]        right_child;
  logic [VAL_W-1:0]         half;
  logic [BASE_W-1:0]        base_half;
  logic [BASE_W+OFF_W-1:0]  base_ext;
  logic                     in_fire;
  logic                     slot_free;
  logic                     req_bad;

  assign n_odd           = n_r[0];
  assign absent          = n_r >= NIDX_W'(NODE_COUNT);
  assign parent_idx      = n_odd ? (n_r >> 1) : ((n_r >> 1) - NIDX_W'(1));
  assign sibling_idx     = n_odd ? (n_r + NIDX_W'(1)) : (n_r - NIDX_W'(1));
  assign right_of_parent = n_odd ? (n_r + NIDX_W'(1)) : n_r;
  assign left_child      = (n_r << 1) + NIDX_W'(1);
  assign right_child     = (n_r << 1) + NIDX_W'(2);
  assign half            = size_r >> 1;
  assign base_half       = base_r + half[BASE_W-1:0];
  assign base_ext        = {{OFF_W{1'b0}}, base_r};

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign req_bad   = (in_request_bytes == '0) ||
                     (CW'(in_request_bytes) > CW'(POOL_BYTES));

  assign out_valid          = out_valid_r;
  assign out_granted        = out_granted_r;
  assign out_granted_offset = out_offset_r;

  bba_mark_ram #(
    .DEPTH  (NODE_COUNT),
    .ADDR_W (NODE_W)
  ) u_marks (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    out_valid_nxt   = out_valid_r;
    want_nxt        = want_r;
    bytes_nxt       = bytes_r;
    target_nxt      = target_r;
    n_nxt           = n_r;
    d_nxt           = d_r;
    size_nxt        = size_r;
    base_nxt        = base_r;
    fresh_nxt       = fresh_r;
    cm_free_nxt     = cm_free_r;
    res_ok_nxt      = res_ok_r;
    res_off_nxt     = res_off_r;
    out_granted_nxt = out_granted_r;
    out_offset_nxt  = out_offset_r;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = n_r[NODE_W-1:0];
    mem_wr_data     = MARK_FREE;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = n_r[NODE_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // sweep every mark to free after reset
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_r;
        mem_wr_data = MARK_FREE;
        clr_nxt     = clr_r + NODE_W'(1);
        if (clr_r == NODE_W'(NODE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          n_nxt       = '0;
          d_nxt       = '0;
          size_nxt    = VAL_W'(POOL_BYTES);
          base_nxt    = '0;
          bytes_nxt   = in_request_bytes;
          target_nxt  = in_block_offset;
          want_nxt    = VAL_W'(MIN_BLOCK_BYTES);
          res_off_nxt = '0;
          if (in_kind == KIND_ALLOC) begin
            res_ok_nxt = 1'b0;
            state_nxt  = req_bad ? ST_RESP : ST_ROUND;
          end else begin
            // a free always reports granted with offset zero
            res_ok_nxt = 1'b1;
            if (TW'(in_block_offset) < TW'(POOL_BYTES)) begin
              state_nxt = ST_F_VISIT;
            end else begin
              state_nxt = ST_RESP;
            end
          end
        end
      end

      // double the minimum block until it covers the request
      ST_ROUND: begin
        if (CW'(want_r) < CW'(bytes_r)) begin
          want_nxt = want_r << 1;
        end else begin
          state_nxt = ST_A_VISIT;
        end
      end

      ST_A_VISIT: begin
        if (absent || (size_r < want_r)) begin
          state_nxt = ST_A_UNWIND;
        end else begin
          mem_rd_en = 1'b1;
          state_nxt = ST_A_DECIDE;
        end
      end

      ST_A_DECIDE: begin
        priority if (mem_rd_data == MARK_USED) begin
          state_nxt = ST_A_UNWIND;
        end else if (mem_rd_data == MARK_FREE) begin
          if (size_r == want_r) begin
            mem_wr_en   = 1'b1;
            mem_wr_data = MARK_USED;
            res_ok_nxt  = 1'b1;
            res_off_nxt = base_ext[OFF_W-1:0];
            state_nxt   = ST_RESP;
          end else if (size_r <= VAL_W'(MIN_BLOCK_BYTES)) begin
            state_nxt = ST_A_UNWIND;
          end else begin
            mem_wr_en        = 1'b1;
            mem_wr_data      = MARK_SPLIT;
            fresh_nxt[d_r]   = 1'b1;
            n_nxt            = left_child;
            d_nxt            = d_r + DEP_W'(1);
            size_nxt         = half;
            state_nxt        = ST_A_VISIT;
          end
        end else begin
          fresh_nxt[d_r] = 1'b0;
          n_nxt          = left_child;
          d_nxt          = d_r + DEP_W'(1);
          size_nxt       = half;
          state_nxt      = ST_A_VISIT;
        end
      end

      // node n failed: try the right sibling or back out of the parent
      ST_A_UNWIND: begin
        if (d_r == '0) begin
          res_ok_nxt  = 1'b0;
          res_off_nxt = '0;
          state_nxt   = ST_RESP;
        end else if (n_odd) begin
          n_nxt     = n_r + NIDX_W'(1);
          base_nxt  = base_r + size_r[BASE_W-1:0];
          state_nxt = ST_A_VISIT;
        end else begin
          // parent failed too; undo a split made on the way down
          if (fresh_r[d_r - DEP_W'(1)]) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = parent_idx[NODE_W-1:0];
            mem_wr_data = MARK_FREE;
          end
          n_nxt    = parent_idx;
          d_nxt    = d_r - DEP_W'(1);
          base_nxt = base_r - size_r[BASE_W-1:0];
          size_nxt = size_r << 1;
        end
      end

      ST_F_VISIT: begin
        if (absent) begin
          state_nxt = ST_RESP;
        end else begin
          mem_rd_en = 1'b1;
          state_nxt = ST_F_DECIDE;
        end
      end

      ST_F_DECIDE: begin
        priority if (mem_rd_data == MARK_USED) begin
          if (TW'(base_r) == TW'(target_r)) begin
            mem_wr_en   = 1'b1;
            mem_wr_data = MARK_FREE;
            cm_free_nxt = 1'b1;
          end else begin
            cm_free_nxt = 1'b0;
          end
          state_nxt = ST_F_CHECK;
        end else if (mem_rd_data == MARK_FREE) begin
          cm_free_nxt = 1'b1;
          state_nxt   = ST_F_CHECK;
        end else begin
          if (TW'(target_r) < TW'(base_half)) begin
            n_nxt = left_child;
          end else begin
            n_nxt    = right_child;
            base_nxt = base_half;
          end
          d_nxt     = d_r + DEP_W'(1);
          size_nxt  = half;
          state_nxt = ST_F_VISIT;
        end
      end

      // merge upward; a parent left split blocks every merge above it
      ST_F_CHECK: begin
        if ((d_r == '0) || !cm_free_r ||
            (right_of_parent >= NIDX_W'(NODE_COUNT))) begin
          state_nxt = ST_RESP;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = sibling_idx[NODE_W-1:0];
          state_nxt   = ST_F_SIB;
        end
      end

      ST_F_SIB: begin
        if (mem_rd_data == MARK_FREE) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = parent_idx[NODE_W-1:0];
          mem_wr_data = MARK_FREE;
          n_nxt       = parent_idx;
          d_nxt       = d_r - DEP_W'(1);
          size_nxt    = size_r << 1;
          state_nxt   = ST_F_CHECK;
        end else begin
          state_nxt = ST_RESP;
        end
      end

      // hand the result word to the output register once it is free
      ST_RESP: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = res_ok_r;
          out_offset_nxt  = res_ok_r ? res_off_r : '0;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    want_r        <= want_nxt;
    bytes_r       <= bytes_nxt;
    target_r      <= target_nxt;
    n_r           <= n_nxt;
    d_r           <= d_nxt;
    size_r        <= size_nxt;
    base_r        <= base_nxt;
    fresh_r       <= fresh_nxt;
    cm_free_r     <= cm_free_nxt;
    res_ok_r      <= res_ok_nxt;
    res_off_r     <= res_off_nxt;
    out_granted_r <= out_granted_nxt;
    out_offset_r  <= out_offset_nxt;
  end

  // sequencing keeps a read and a write of the same mark in separate cycles
  a_no_same_cycle_rw: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
    else $error("mark read and write collide");

  // one word in the walk at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second word accepted during a walk");

  // a refused allocation never carries an offset
  a_fail_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_granted_offset == '0))
    else $error("failed allocation with nonzero offset");

  // walk depth stays inside the tree plus one absent level
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR && state_r != ST_IDLE) |-> (d_r <= DEP_W'(LVL)))
    else $error("walk depth out of range");

  // memory reads only target nodes that exist
  a_read_in_tree: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_rd_en && state_r != ST_F_CHECK) |-> !absent)
    else $error("read of an absent node");

endmodule

// ===== src/bba_mark_ram.sv =====
`timescale 1ns / 1ps

module bba_mark_ram
  import bba_pkg::*;
#(
  parameter int DEPTH  = DEF_NODE_COUNT,
  parameter int ADDR_W = $clog2(DEF_NODE_COUNT)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  mark_t             wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output mark_t             rd_data
);

  mark_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read; rd_data holds its value while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
